// ===== hdl/spt_pkg.sv =====
// Shared definitions for the sorted peer table: operation and status codes
// and the search token that travels down the cell chain.
// No dependencies.
package spt_pkg;

  // Operation codes carried in the func field
  localparam logic [2:0] FN_ADD      = 3'd0;
  localparam logic [2:0] FN_LOOKUP   = 3'd1;
  localparam logic [2:0] FN_UP       = 3'd2;
  localparam logic [2:0] FN_CONN_ADD = 3'd3;
  localparam logic [2:0] FN_CONN_DEL = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Search token flags, one register set per cell
  typedef struct packed {
    logic valid;  // token present at this cell output
    logic done;   // insertion point already found upstream
    logic hit;    // key matched at the insertion point
  } tok_t;

endpackage

// ===== hdl/sorted_peer_table_with_liveness.sv =====
// Peer table with liveness: top level with the sorted cell chain, the
// per-slot liveness RAM and the operation sequencer.
// Depends on spt_pkg, spt_cell and spt_ram.
//
// Usage:
//   One request transaction on the s_ side gives exactly one response
//   transaction on the m_ side. Requests are add, lookup, up notify, add
//   connection and remove connection. Keys sit in a chain of TABLE_DEPTH
//   cells in sorted order; connection counts and dead marks live in a RAM
//   indexed by slot.
//   Add and lookup are timed by the search token that enters the chain the
//   cycle after acceptance and steps one cell per clock; an existing key
//   then adds the registered RAM read before the response register. Notify
//   and connection requests are timed by the registered RAM read; an unused
//   slot or an unknown func goes straight to the response register. One
//   request is in work at a time; s_tready is high while the sequencer is
//   idle.
//   A new request may be accepted while the previous response still waits in
//   the output register; its own response then waits until that one is taken.
//   Reset empties the table (entry count zero, all cells invalid); no clearing
//   pass is needed and requests are taken the cycle after reset drops.
//   A stalled m_tready holds the response and its payload steady.
module sorted_peer_table_with_liveness #(
  parameter int TABLE_DEPTH = 64,
  parameter int CONN_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func[2:0], peer_ip[34:3], peer_port[50:35], slot[56:51], zero fill above
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], found_slot[7:2], is_dead[8], conn_count[24:9], changed[25]
  output logic [31:0] m_tdata
);

  import spt_pkg::*;

  localparam int SW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CNTW > 6) ? CNTW : 6;
  localparam int OW   = (CONN_WIDTH > 16) ? CONN_WIDTH : 16;
  localparam logic [CONN_WIDTH-1:0] CONN_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state;

  // Request fields
  logic [2:0]      in_func;
  logic [31:0]     in_ip;
  logic [15:0]     in_port;
  logic [5:0]      in_slot;
  logic [CMPW-1:0] in_slot_w;
  logic [SW-1:0]   in_slot_sw;
  logic            accept;

  assign in_func    = s_tdata[2:0];
  assign in_ip      = s_tdata[34:3];
  assign in_port    = s_tdata[50:35];
  assign in_slot    = s_tdata[56:51];
  assign in_slot_w  = CMPW'(in_slot);
  assign in_slot_sw = in_slot_w[SW-1:0];
  assign s_tready   = (state == S_IDLE) && !rst;
  assign accept     = s_tvalid && s_tready;

  function automatic logic slot_op_in(input logic [2:0] f);
    return (f == FN_UP) || (f == FN_CONN_ADD) || (f == FN_CONN_DEL);
  endfunction

  // Held request
  logic [2:0]      func;
  logic [31:0]     probe_ip;
  logic [15:0]     probe_port;
  logic [SW-1:0]   rd_slot;
  logic [CNTW-1:0] cnt;

  // Cell chain wiring
  tok_t            tok      [TABLE_DEPTH];
  logic [SW-1:0]   tok_slot [TABLE_DEPTH];
  logic [31:0]     c_ip     [TABLE_DEPTH];
  logic [15:0]     c_port   [TABLE_DEPTH];
  logic [SW-1:0]   c_slot   [TABLE_DEPTH];
  logic            c_valid  [TABLE_DEPTH];
  logic            c_shift  [TABLE_DEPTH];
  tok_t            tok_head;
  logic            launch;
  logic            tok_start;
  logic            ins;

  assign launch   = accept && ((in_func == FN_ADD) || (in_func == FN_LOOKUP));
  assign tok_head = '{valid: tok_start, done: 1'b0, hit: 1'b0};

  // Token enters the chain once the probe key is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_start <= 1'b0;
    end else begin
      tok_start <= launch;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spt_cell #(.SW(SW)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .probe_ip     (probe_ip),
        .probe_port   (probe_port),
        .tok_in       (tok_head),
        .tok_slot_in  ('0),
        .tok_out      (tok[i]),
        .tok_slot_out (tok_slot[i]),
        .ins          (ins),
        .new_slot     (cnt[SW-1:0]),
        .prev_ip      ('0),
        .prev_port    ('0),
        .prev_slot    ('0),
        .prev_valid   (1'b0),
        .prev_shift   (1'b0),
        .ip           (c_ip[i]),
        .port         (c_port[i]),
        .slot         (c_slot[i]),
        .valid        (c_valid[i]),
        .shift        (c_shift[i])
      );
    end else begin : g_body
      spt_cell #(.SW(SW)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .probe_ip     (probe_ip),
        .probe_port   (probe_port),
        .tok_in       (tok[i-1]),
        .tok_slot_in  (tok_slot[i-1]),
        .tok_out      (tok[i]),
        .tok_slot_out (tok_slot[i]),
        .ins          (ins),
        .new_slot     (cnt[SW-1:0]),
        .prev_ip      (c_ip[i-1]),
        .prev_port    (c_port[i-1]),
        .prev_slot    (c_slot[i-1]),
        .prev_valid   (c_valid[i-1]),
        .prev_shift   (c_shift[i-1]),
        .ip           (c_ip[i]),
        .port         (c_port[i]),
        .slot         (c_slot[i]),
        .valid        (c_valid[i]),
        .shift        (c_shift[i])
      );
    end
  end

  // Search outcome at the tail of the chain
  tok_t          tok_last;
  logic [SW-1:0] tok_last_slot;
  logic          walk_end;
  logic          table_full;

  assign tok_last      = tok[TABLE_DEPTH-1];
  assign tok_last_slot = tok_slot[TABLE_DEPTH-1];
  assign walk_end      = (state == S_WALK) && tok_last.valid;
  assign table_full    = (cnt == CNTW'(TABLE_DEPTH));
  assign ins           = walk_end && (func == FN_ADD) && !tok_last.hit && !table_full;

  // Liveness RAM: {dead, conns} per slot
  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  logic [CONN_WIDTH:0]   ram_wdata;
  logic [SW-1:0]         ram_raddr;
  logic [CONN_WIDTH:0]   ram_rdata;
  logic                  rd_dead;
  logic [CONN_WIDTH-1:0] rd_conns;

  assign rd_dead  = ram_rdata[CONN_WIDTH];
  assign rd_conns = ram_rdata[CONN_WIDTH-1:0];

  spt_ram #(.WIDTH(CONN_WIDTH + 1), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read-modify for notify and connection operations
  logic                  slot_op;
  logic                  new_dead;
  logic [CONN_WIDTH-1:0] new_conns;
  logic                  new_chg;

  assign slot_op = (func == FN_UP) || (func == FN_CONN_ADD) || (func == FN_CONN_DEL);

  always_comb begin
    new_dead  = rd_dead;
    new_conns = rd_conns;
    new_chg   = 1'b0;
    priority if (func == FN_UP) begin
      new_dead = 1'b0;
      new_chg  = rd_dead;
    end else if (func == FN_CONN_ADD) begin
      if (rd_conns != CONN_MAX) begin
        new_conns = rd_conns + 1'b1;
      end
    end else if (func == FN_CONN_DEL) begin
      if (rd_conns != '0) begin
        new_conns = rd_conns - 1'b1;
        if ((rd_conns == CONN_WIDTH'(1)) && !rd_dead) begin
          new_dead = 1'b1;
          new_chg  = 1'b1;
        end
      end
    end
  end

  // RAM port selection
  always_comb begin
    ram_raddr = (state == S_IDLE) ? in_slot_sw : tok_last_slot;
    ram_we    = ins || ((state == S_READ) && slot_op);
    ram_waddr = ins ? cnt[SW-1:0] : rd_slot;
    ram_wdata = ins ? {1'b1, {CONN_WIDTH{1'b0}}} : {new_dead, new_conns};
  end

  // Width adapters onto the response fields
  logic [CMPW-1:0] cnt_w;
  logic [CMPW-1:0] rd_slot_w;
  logic [OW-1:0]   rd_conns_w;
  logic [OW-1:0]   new_conns_w;

  assign cnt_w       = CMPW'(cnt);
  assign rd_slot_w   = CMPW'(rd_slot);
  assign rd_conns_w  = OW'(rd_conns);
  assign new_conns_w = OW'(new_conns);

  // Pending response
  logic [1:0]  res_status;
  logic [5:0]  res_slot;
  logic        res_dead;
  logic [15:0] res_conns;
  logic        res_chg;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (launch) begin
              state <= S_WALK;
            end else if (slot_op_in(in_func) && (in_slot_w < cnt_w)) begin
              state <= S_READ;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_WALK: begin
          if (walk_end) begin
            state <= tok_last.hit ? S_READ : S_RESP;
            if (ins) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and response building
  always_ff @(posedge clk) begin
    if (accept) begin
      func       <= in_func;
      probe_ip   <= in_ip;
      probe_port <= in_port;
      rd_slot    <= in_slot_sw;
      res_status <= ST_NOTFOUND;
      res_slot   <= slot_op_in(in_func) ? in_slot : 6'd0;
      res_dead   <= 1'b0;
      res_conns  <= '0;
      res_chg    <= 1'b0;
    end
    if (walk_end) begin
      rd_slot <= tok_last_slot;
      if (!tok_last.hit && (func == FN_ADD)) begin
        if (table_full) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
          res_slot   <= cnt_w[5:0];
          res_dead   <= 1'b1;
        end
      end
    end
    if (state == S_READ) begin
      res_slot <= rd_slot_w[5:0];
      if (slot_op) begin
        res_status <= ST_OK;
        res_dead   <= new_dead;
        res_conns  <= new_conns_w[15:0];
        res_chg    <= new_chg;
      end else begin
        res_status <= (func == FN_ADD) ? ST_EXISTS : ST_OK;
        res_dead   <= rd_dead;
        res_conns  <= rd_conns_w[15:0];
      end
    end
  end

  // Output register
  logic load_out;

  assign load_out = (state == S_RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'd0, res_chg, res_conns, res_dead, res_slot, res_status};
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst) cnt <= CNTW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  assert property (@(posedge clk) disable iff (rst) tok_last.valid |-> state == S_WALK)
    else $error("search token left the chain outside a search");

  assert property (@(posedge clk) disable iff (rst) ins |=> cnt == $past(cnt) + 1'b1)
    else $error("insert did not grow the table by one");

  assert property (@(posedge clk) disable iff (rst) launch |-> !tok[0].valid)
    else $error("search launched while a token is in the chain head");

endmodule

// ===== hdl/spt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/spt_cell.sv =====
// One sorted position of the peer table: holds a key and its slot, compares
// it against the probe key as the search token passes, and shifts on insert.
// Depends on spt_pkg.
module spt_cell #(
  parameter int SW = 6
) (
  input  logic              clk,
  input  logic              rst,
  // probe key, held steady during a search
  input  logic [31:0]       probe_ip,
  input  logic [15:0]       probe_port,
  // search token from the upstream neighbor
  input  spt_pkg::tok_t     tok_in,
  input  logic [SW-1:0]     tok_slot_in,
  output spt_pkg::tok_t     tok_out,
  output logic [SW-1:0]     tok_slot_out,
  // insert control and upstream neighbor contents
  input  logic              ins,
  input  logic [SW-1:0]     new_slot,
  input  logic [31:0]       prev_ip,
  input  logic [15:0]       prev_port,
  input  logic [SW-1:0]     prev_slot,
  input  logic              prev_valid,
  input  logic              prev_shift,
  // own contents, to the downstream neighbor
  output logic [31:0]       ip,
  output logic [15:0]       port,
  output logic [SW-1:0]     slot,
  output logic              valid,
  output logic              shift
);

  import spt_pkg::*;

  logic key_lt;
  logic key_eq;
  logic stop;

  // Key order: unsigned ip first, then port
  assign key_eq = (ip == probe_ip) && (port == probe_port);
  assign key_lt = (ip < probe_ip) || ((ip == probe_ip) && (port < probe_port));
  assign stop   = !valid || !key_lt;

  // Token stage: search continues past smaller keys, stops at the first
  // empty cell or key that is not smaller
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        if (tok_in.done || !stop) begin
          tok_out.done <= tok_in.done;
          tok_out.hit  <= tok_in.hit;
        end else begin
          tok_out.done <= 1'b1;
          tok_out.hit  <= valid && key_eq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tok_slot_out <= (tok_in.done || !stop) ? tok_slot_in : slot;
    end
  end

  // Shift mark: this cell sits at or after the insertion point
  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= 1'b0;
    end else if (tok_in.valid) begin
      shift <= tok_in.done || stop;
    end
  end

  // Valid bit follows the contents on insert
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins && shift) begin
      valid <= prev_shift ? prev_valid : 1'b1;
    end
  end

  // Key and slot: take the neighbor's entry, or the new one at the insertion point
  always_ff @(posedge clk) begin
    if (ins && shift) begin
      if (prev_shift) begin
        ip   <= prev_ip;
        port <= prev_port;
        slot <= prev_slot;
      end else begin
        ip   <= probe_ip;
        port <= probe_port;
        slot <= new_slot;
      end
    end
  end

endmodule
